// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, command and status codes, and the per-cycle control struct
// broadcast from the queue controller to every cell of the sorted chain.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int PRIO_W   = 16;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 2;
  localparam int ECOUNT_W = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_NEXT   = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // one operation applied to the whole chain in a single cycle
  typedef struct packed {
    logic                ins;
    logic                pop;
    logic [PRIO_W-1:0]   prio;
    logic [HANDLE_W-1:0] handle;
  } op_t;

endpackage : spq_pkg
`default_nettype wire

// ===== sv/spq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. Compares the incoming priority locally and
// either keeps its entry, takes the new entry, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  wire logic                           clk,
  input  wire spq_pkg::op_t                   op,
  input  wire logic                           occupied,
  input  wire logic                           left_ge,
  input  wire logic [spq_pkg::PRIO_W-1:0]     left_prio,
  input  wire logic [spq_pkg::HANDLE_W-1:0]   left_handle,
  input  wire logic [spq_pkg::PRIO_W-1:0]     right_prio,
  input  wire logic [spq_pkg::HANDLE_W-1:0]   right_handle,
  output logic                                ge,
  output logic [spq_pkg::PRIO_W-1:0]          prio,
  output logic [spq_pkg::HANDLE_W-1:0]        handle
);

  // stored entry ranks at or ahead of the new one: it stays put
  assign ge = occupied && ($signed(prio) >= $signed(op.prio));

  always_ff @(posedge clk) begin
    if (op.pop) begin
      prio   <= right_prio;
      handle <= right_handle;
    end else if (op.ins && !ge) begin
      if (left_ge) begin
        prio   <= op.prio;
        handle <= op.handle;
      end else begin
        prio   <= left_prio;
        handle <= left_handle;
      end
    end
  end

endmodule : spq_cell
`default_nettype wire

// ===== sv/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a chain of cells sorted by signed priority,
// highest first, FIFO among equal priorities. One response per request.
// ----------------------------------------------------------------------------
// Response: registered, valid in the cycle after the request is accepted.
// Throughput: 1 request per cycle unless m_tready holds back a response; every
//   cell compares and shifts in the same cycle, absorbing an insert or a next.
// Reset: rst clears the entry count and the response valid; response data
//   and slot contents are not cleared, and slots are only read below the count.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [0] cmd, [32:1] item_handle, [48:33] priority_req, [55:49] zero
  input  wire logic [spq_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [1:0] status, [33:2] out_handle, [38:34] entry_count, [39] zero
  output logic [spq_pkg::OUT_DATA_W-1:0]         m_tdata
);

  localparam int CAP   = spq_pkg::CAPACITY;
  localparam int CNT_W = spq_pkg::CNT_W;

  logic [CNT_W-1:0]                count;
  logic [CNT_W-1:0]                count_next;
  logic [spq_pkg::STATUS_W-1:0]    status;
  logic [spq_pkg::HANDLE_W-1:0]    out_handle;
  logic [spq_pkg::ECOUNT_W-1:0]    entry_count;

  logic                            accept;
  spq_pkg::cmd_t                   cmd;
  logic                            is_full;
  logic                            is_empty;
  spq_pkg::op_t                    op;
  logic [CNT_W+spq_pkg::ECOUNT_W-1:0] count_ext;

  logic                            ge     [CAP];
  logic [spq_pkg::PRIO_W-1:0]      prio   [CAP];
  logic [spq_pkg::HANDLE_W-1:0]    handle [CAP];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign cmd      = spq_pkg::cmd_t'(s_tdata[0]);
  assign is_full  = (count == CNT_W'(CAP));
  assign is_empty = (count == '0);

  always_comb begin
    op.ins    = accept && (cmd == spq_pkg::CMD_INSERT) && !is_full;
    op.pop    = accept && (cmd == spq_pkg::CMD_NEXT) && !is_empty;
    op.handle = s_tdata[32:1];
    op.prio   = s_tdata[48:33];
  end

  always_comb begin
    count_next = count;
    if (op.ins) begin
      count_next = count + CNT_W'(1);
    end else if (op.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  // entry_count carries the low bits of the count
  assign count_ext = {{spq_pkg::ECOUNT_W{1'b0}}, count_next};

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic                          left_ge;
    logic [spq_pkg::PRIO_W-1:0]    left_prio;
    logic [spq_pkg::HANDLE_W-1:0]  left_handle;
    logic [spq_pkg::PRIO_W-1:0]    right_prio;
    logic [spq_pkg::HANDLE_W-1:0]  right_handle;

    if (i == 0) begin : g_head
      assign left_ge     = 1'b1;
      assign left_prio   = '0;
      assign left_handle = '0;
    end else begin : g_body
      assign left_ge     = ge[i-1];
      assign left_prio   = prio[i-1];
      assign left_handle = handle[i-1];
    end

    if (i == CAP - 1) begin : g_tail
      assign right_prio   = '0;
      assign right_handle = '0;
    end else begin : g_inner
      assign right_prio   = prio[i+1];
      assign right_handle = handle[i+1];
    end

    spq_cell u_cell (
      .clk          (clk),
      .op           (op),
      .occupied     (count > CNT_W'(i)),
      .left_ge      (left_ge),
      .left_prio    (left_prio),
      .left_handle  (left_handle),
      .right_prio   (right_prio),
      .right_handle (right_handle),
      .ge           (ge[i]),
      .prio         (prio[i]),
      .handle       (handle[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_count <= count_ext[spq_pkg::ECOUNT_W-1:0];
      out_handle  <= op.pop ? handle[0] : '0;
      if (cmd == spq_pkg::CMD_INSERT) begin
        status <= is_full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_OK;
      end else begin
        status <= is_empty ? spq_pkg::STATUS_EMPTY : spq_pkg::STATUS_OK;
      end
    end
  end

  assign m_tdata = {1'b0, entry_count, out_handle, status};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAP))
    else $error("entry count above capacity");

  a_resp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted request produced no response");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == spq_pkg::CMD_INSERT) && is_full
      |=> (status == spq_pkg::STATUS_FULL) && $stable(count))
    else $error("insert into full queue not dropped");

  a_empty_next: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == spq_pkg::CMD_NEXT) && is_empty
      |=> (status == spq_pkg::STATUS_EMPTY) && (out_handle == '0))
    else $error("next on empty queue misreported");

endmodule : sorted_priority_queue
`default_nettype wire
